@@ hw/rtl/assert_macros.svh @@
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/htfc_pkg.sv @@
// constants shared by the frame check and conversion block
package htfc_pkg;

  localparam int unsigned CRC_W = 8;

  localparam logic [CRC_W-1:0] CRC_POLY = 8'h31;
  localparam logic [CRC_W-1:0] CRC_INIT = 8'hFF;
  localparam logic [CRC_W-1:0] CRC_TOP  = 8'h80;

  localparam logic [14:0] T_SPAN   = 15'd17500;
  localparam logic [15:0] T_OFFSET = 16'd4500;
  localparam logic [13:0] H_SPAN   = 14'd12500;
  localparam logic [13:0] H_OFFSET = 14'd600;
  localparam logic [13:0] H_MAX    = 14'd10000;
  localparam logic [16:0] RAW_FULL = 17'd65535;

endpackage

@@ hw/rtl/htfc_crc_byte.sv @@
// one byte of crc-8 update, msb first
module htfc_crc_byte
  import htfc_pkg::*;
(
  input  logic [CRC_W-1:0] crc_in,
  input  logic [7:0]       data,
  output logic [CRC_W-1:0] crc_out
);

  always_comb begin
    logic [CRC_W-1:0] c;
    c = crc_in ^ data;
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != '0) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    crc_out = c;
  end

endmodule

@@ hw/rtl/humidity_temp_frame_check_convert_top.sv @@
// top level: frame crc check and conversion pipeline
// Three-stage pipeline that takes one frame per cycle while the output is not
// held back and gives one result per frame. Stage one does the crc over the high
// bytes and the two scaling multiplies, stage two the crc over the low bytes and
// the division by 65535 (adds and a compare), stage three the offsets,
// humidity clamp and zeroing of a failed frame. Back pressure on the output
// stalls stages only as far back as they are full; no frame is lost or repeated.
module humidity_temp_frame_check_convert_top
  import htfc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        temp_word,
  input  logic [7:0]         temp_check,
  input  logic [15:0]        hum_word,
  input  logic [7:0]         hum_check,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               frame_ok,
  output logic signed [14:0] temp_centi,
  output logic [13:0]        hum_centi
);

`include "assert_macros.svh"

  typedef struct packed {
    logic [7:0]       t_low;
    logic [7:0]       h_low;
    logic [CRC_W-1:0] t_crc;
    logic [CRC_W-1:0] h_crc;
    logic [7:0]       t_check;
    logic [7:0]       h_check;
    logic [30:0]      t_prod;
    logic [29:0]      h_prod;
  } s1_t;

  typedef struct packed {
    logic        ok;
    logic [14:0] t_q;
    logic [13:0] h_q;
  } s2_t;

  logic v1, v2, v3;
  logic ld1, ld2, ld3;
  s1_t  s1, s1_next;
  s2_t  s2, s2_next;

  logic [CRC_W-1:0] t_crc_hi, h_crc_hi, t_crc_lo, h_crc_lo;
  logic [16:0]      t_sum, h_sum;
  logic signed [15:0] t_val;
  logic [13:0]        h_val;

  logic               frame_ok_next;
  logic signed [14:0] temp_centi_next;
  logic [13:0]        hum_centi_next;

  assign ld3      = !v3 || out_ready;
  assign ld2      = !v2 || ld3;
  assign ld1      = !v1 || ld2;
  assign in_ready = ld1;
  assign out_valid = v3;

  htfc_crc_byte u_t_hi (.crc_in(CRC_INIT), .data(temp_word[15:8]), .crc_out(t_crc_hi));
  htfc_crc_byte u_h_hi (.crc_in(CRC_INIT), .data(hum_word[15:8]),  .crc_out(h_crc_hi));
  htfc_crc_byte u_t_lo (.crc_in(s1.t_crc), .data(s1.t_low),        .crc_out(t_crc_lo));
  htfc_crc_byte u_h_lo (.crc_in(s1.h_crc), .data(s1.h_low),        .crc_out(h_crc_lo));

  // stage one: high byte crc and scaling products
  always_comb begin
    s1_next.t_low   = temp_word[7:0];
    s1_next.h_low   = hum_word[7:0];
    s1_next.t_crc   = t_crc_hi;
    s1_next.h_crc   = h_crc_hi;
    s1_next.t_check = temp_check;
    s1_next.h_check = hum_check;
    s1_next.t_prod  = 31'(T_SPAN) * 31'(temp_word);
    s1_next.h_prod  = 30'(H_SPAN) * 30'(hum_word);
  end

  // stage two: floor(p / 65535) = hi + ((hi + lo) >= 65535)
  always_comb begin
    t_sum = 17'(s1.t_prod[30:16]) + 17'(s1.t_prod[15:0]);
    h_sum = 17'(s1.h_prod[29:16]) + 17'(s1.h_prod[15:0]);
    s2_next.ok  = (t_crc_lo == s1.t_check) && (h_crc_lo == s1.h_check);
    s2_next.t_q = s1.t_prod[30:16] + 15'(t_sum >= RAW_FULL);
    s2_next.h_q = s1.h_prod[29:16] + 14'(h_sum >= RAW_FULL);
  end

  // stage three: offsets, clamp, zero on failure
  always_comb begin
    t_val = $signed({1'b0, s2.t_q}) - $signed(T_OFFSET);
    if (s2.h_q < H_OFFSET) begin
      h_val = '0;
    end else if (s2.h_q - H_OFFSET > H_MAX) begin
      h_val = H_MAX;
    end else begin
      h_val = s2.h_q - H_OFFSET;
    end
    frame_ok_next   = s2.ok;
    temp_centi_next = s2.ok ? t_val[14:0] : '0;
    hum_centi_next  = s2.ok ? h_val : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ld1) v1 <= in_valid;
      if (ld2) v2 <= v1;
      if (ld3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1 && in_valid) s1 <= s1_next;
    if (ld2 && v1)       s2 <= s2_next;
    if (ld3 && v2) begin
      frame_ok   <= frame_ok_next;
      temp_centi <= temp_centi_next;
      hum_centi  <= hum_centi_next;
    end
  end

  `ASSERT_CLK(a_fail_zero, out_valid && !frame_ok |-> temp_centi == '0 && hum_centi == '0,
              "failed frame with nonzero values")
  `ASSERT_CLK(a_hum_clamp, out_valid |-> hum_centi <= H_MAX, "humidity above clamp")
  `ASSERT_CLK(a_s1_hold, v1 && !ld2 |=> v1 && $stable(s1), "stalled stage one changed")
  `ASSERT_ALWAYS(a_rst_empty, rst |=> !v1 && !v2 && !v3, "pipeline not empty after reset")

endmodule

@@ verif/tb.sv @@
// testbench for the humidity and temperature frame check and conversion block
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CRC_POLY_C = 8'h31;
  localparam logic [7:0] CRC_SEED_C = 8'hFF;
  localparam int unsigned TEMP_SPAN_C = 17500;
  localparam int TEMP_OFFSET_C = -4500;
  localparam int unsigned HUM_SPAN_C = 12500;
  localparam int HUM_OFFSET_C = -600;
  localparam int HUM_MAX_C = 10000;
  localparam int unsigned RAW_FULL_C = 65535;
  localparam int RANDOM_FRAMES = 1630;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct {
    logic               ok;
    logic signed [14:0] temp;
    logic [13:0]        hum;
  } reading_t;

  class frame_scoreboard;
    reading_t pending_readings[$];
    int errors;

    static function logic [7:0] word_crc(logic [15:0] w);
      logic [7:0] c;
      c = CRC_SEED_C;
      for (int b = 1; b >= 0; b--) begin
        c = c ^ w[b*8 +: 8];
        for (int k = 0; k < 8; k++) begin
          if (c[7]) begin
            c = (c << 1) ^ CRC_POLY_C;
          end else begin
            c = c << 1;
          end
        end
      end
      return c;
    endfunction

    function reading_t predict_reading(logic [15:0] tw, logic [7:0] tc,
                                       logic [15:0] hw, logic [7:0] hc);
      reading_t r;
      int unsigned tw_u;
      int unsigned hw_u;
      int t;
      int rh;
      tw_u = tw;
      hw_u = hw;
      t = 0;
      rh = 0;
      r.ok = (word_crc(tw) == tc) && (word_crc(hw) == hc);
      if (r.ok) begin
        t = TEMP_OFFSET_C + int'((TEMP_SPAN_C * tw_u) / RAW_FULL_C);
        rh = HUM_OFFSET_C + int'((HUM_SPAN_C * hw_u) / RAW_FULL_C);
        if (rh < 0) rh = 0;
        if (rh > HUM_MAX_C) rh = HUM_MAX_C;
      end
      r.temp = t[14:0];
      r.hum = rh[13:0];
      return r;
    endfunction

    function void note_frame(logic [15:0] tw, logic [7:0] tc,
                             logic [15:0] hw, logic [7:0] hc);
      pending_readings.push_back(predict_reading(tw, tc, hw, hc));
    endfunction

    function void check_result(logic ok, logic signed [14:0] temp, logic [13:0] hum);
      reading_t e;
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected result ok=%0b temp=%0d hum=%0d", $time, ok, temp, hum);
        errors++;
        return;
      end
      e = pending_readings.pop_front();
      if (ok !== e.ok) begin
        $display("%0t: frame_ok expected %0b actual %0b", $time, e.ok, ok);
        errors++;
      end
      if (temp !== e.temp) begin
        $display("%0t: temp_centi expected %0d actual %0d", $time, e.temp, temp);
        errors++;
      end
      if (hum !== e.hum) begin
        $display("%0t: hum_centi expected %0d actual %0d", $time, e.hum, hum);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [15:0]        temp_word;
  logic [7:0]         temp_check;
  logic [15:0]        hum_word;
  logic [7:0]         hum_check;
  logic               out_valid;
  logic               out_ready;
  logic               frame_ok;
  logic signed [14:0] temp_centi;
  logic [13:0]        hum_centi;

  frame_scoreboard readings = new();
  bit no_idle;
  int idle_cycles;

  humidity_temp_frame_check_convert_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .temp_word  (temp_word),
    .temp_check (temp_check),
    .hum_word   (hum_word),
    .hum_check  (hum_check),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_ok   (frame_ok),
    .temp_centi (temp_centi),
    .hum_centi  (hum_centi)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // called and returns at a falling edge
  task automatic send_frame(logic [15:0] tw, logic [7:0] tc, logic [15:0] hw, logic [7:0] hc);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    temp_word <= tw;
    temp_check <= tc;
    hum_word <= hw;
    hum_check <= hc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_good_frame(logic [15:0] tw, logic [15:0] hw);
    send_frame(tw, frame_scoreboard::word_crc(tw), hw, frame_scoreboard::word_crc(hw));
  endtask

  function automatic logic [15:0] random_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 16'($urandom_range(0, 3200));
    if (r < 10) return 16'($urandom_range(55000, 65535));
    return 16'($urandom);
  endfunction

  // transfers are noted and checked at the same rising edge the dut sees them
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) readings.note_frame(temp_word, temp_check, hum_word, hum_check);
      if (out_valid && out_ready) readings.check_result(frame_ok, temp_centi, hum_centi);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // output back pressure
  initial begin
    int hold;
    bit ready_now;
    hold = 0;
    ready_now = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0) begin
        ready_now = !ready_now;
        if (ready_now) begin
          hold = $urandom_range(1, 30);
        end else begin
          hold = pick_gap();
          if (hold == 0) begin
            hold = 1;
            ready_now = 1'b1;
          end
        end
      end
      hold--;
      out_ready <= no_idle ? 1'b1 : ready_now;
    end
  end

  initial begin
    logic [15:0] tw;
    logic [15:0] hw;
    logic [7:0] tc;
    logic [7:0] hc;
    logic [15:0] boundary_words[$];
    int kind;
    rst = 1'b1;
    in_valid = 1'b0;
    temp_word = '0;
    temp_check = '0;
    hum_word = '0;
    hum_check = '0;
    no_idle = 1'b0;
    idle_cycles = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // word extremes
    send_good_frame(16'h0000, 16'h0000);
    send_good_frame(16'hFFFF, 16'hFFFF);
    send_good_frame(16'h0000, 16'hFFFF);
    send_good_frame(16'hFFFF, 16'h0000);
    send_good_frame(16'h8000, 16'h7FFF);
    // humidity words around the low clamp edge and the H_MAX output value
    boundary_words = '{16'd3144, 16'd3145, 16'd3146, 16'd3147,
                       16'd55573, 16'd55574, 16'd55575, 16'd55576};
    foreach (boundary_words[i]) send_good_frame(16'($urandom), boundary_words[i]);
    // crc mismatch on temperature, humidity, both
    tw = 16'h6A5C;
    hw = 16'h93A1;
    send_frame(tw, frame_scoreboard::word_crc(tw) ^ 8'h01, hw, frame_scoreboard::word_crc(hw));
    send_frame(tw, frame_scoreboard::word_crc(tw), hw, frame_scoreboard::word_crc(hw) ^ 8'h80);
    send_frame(tw, ~frame_scoreboard::word_crc(tw), hw, ~frame_scoreboard::word_crc(hw));
    send_frame(16'hFFFF, frame_scoreboard::word_crc(16'hFFFF) ^ 8'h10, 16'hFFFF,
               frame_scoreboard::word_crc(16'hFFFF));
    // check byte extremes, both matching and not
    for (int target = 0; target <= 255; target += 255) begin
      tw = 16'h0000;
      while (frame_scoreboard::word_crc(tw) != 8'(target)) tw++;
      send_frame(tw, 8'(target), tw, 8'(target));
      send_frame(tw, 8'(target), hw, 8'(target));
    end
    send_frame(16'h1234, 8'h00, 16'h5678, 8'hFF);

    for (int n = 0; n < RANDOM_FRAMES; n++) begin
      no_idle = ((n / 150) % 4) == 3;
      tw = random_word();
      hw = random_word();
      tc = frame_scoreboard::word_crc(tw);
      hc = frame_scoreboard::word_crc(hw);
      kind = $urandom_range(0, 99);
      if (kind >= 94) begin
        tc = tc ^ 8'($urandom_range(1, 255));
        hc = hc ^ 8'($urandom_range(1, 255));
      end else if (kind >= 88) begin
        tc = 8'($urandom);
        hc = 8'($urandom);
      end else if (kind >= 84) begin
        tc = tc ^ (8'h01 << $urandom_range(0, 7));
      end else if (kind >= 80) begin
        hc = hc ^ (8'h01 << $urandom_range(0, 7));
      end
      send_frame(tw, tc, hw, hc);
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;

    while (readings.pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    readings.errors += readings.pending_readings.size();
    if (readings.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/htfc_pkg.sv
hw/rtl/htfc_crc_byte.sv
hw/rtl/humidity_temp_frame_check_convert_top.sv
verif/tb.sv
